@@ sv/cau_pkg.sv @@
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes, default widths and shared pipeline types.
// ---------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int OP_W           = 4;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_NEG  = 4'd4,
      OP_CONJ = 4'd5,
      OP_MOD  = 4'd6,
      OP_EQ   = 4'd7,
      OP_INC  = 4'd8,
      OP_DEC  = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_DIV    = 2'd1,
      KIND_SQRT   = 2'd2
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     is_equal;
      logic     dz;
   } ctl_type;

endpackage

@@ sv/cau_front.sv @@
// ---------------------------------------------------------------------------
// Complex arithmetic unit front end
// Products, sums and simple operations; prepares divider and root operands.
// ---------------------------------------------------------------------------
module cau_front #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
   parameter int NW         = 2 * DATA_WIDTH + 2,
   parameter int QW         = 2 * DATA_WIDTH + FRAC_BITS + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [cau_pkg::OP_W-1:0]     in_op,
   input  logic signed [DATA_WIDTH-1:0] a_re,
   input  logic signed [DATA_WIDTH-1:0] a_im,
   input  logic signed [DATA_WIDTH-1:0] b_re,
   input  logic signed [DATA_WIDTH-1:0] b_im,
   output cau_pkg::ctl_type             ctl,
   output logic signed [NW-1:0]         re_out,
   output logic signed [NW-1:0]         im_out,
   output logic [QW-1:0]                num_re,
   output logic [QW-1:0]                num_im,
   output logic                         neg_re,
   output logic                         neg_im,
   output logic [NW-1:0]                den
);

   localparam int PW = 2 * DATA_WIDTH;

   // Stage one: the four cross products and the squares of a_re and a_im.
   logic signed [PW-1:0] rr_ff, ii_ff, ri_ff, ir_ff, rr_in, ii_in, ri_in, ir_in;
   logic signed [PW-1:0] aa_ff, bb_ff, aa_in, bb_in;
   logic signed [DATA_WIDTH-1:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic [cau_pkg::OP_W-1:0] op_ff;
   logic v1_ff, eq1_ff;

   always_comb begin
      rr_in = PW'(a_re) * PW'(b_re);
      ii_in = PW'(a_im) * PW'(b_im);
      ri_in = PW'(a_re) * PW'(b_im);
      ir_in = PW'(a_im) * PW'(b_re);
      aa_in = PW'(a_re) * PW'(a_re);
      bb_in = PW'(a_im) * PW'(a_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
      end
      if (enable) begin
         rr_ff  <= rr_in;
         ii_ff  <= ii_in;
         ri_ff  <= ri_in;
         ir_ff  <= ir_in;
         aa_ff  <= aa_in;
         bb_ff  <= bb_in;
         ar_ff  <= a_re;
         ai_ff  <= a_im;
         br_ff  <= b_re;
         bi_ff  <= b_im;
         op_ff  <= in_op;
         eq1_ff <= (a_re == b_re) && (a_im == b_im);
      end
   end

   // Stage two: sums and simple operations.
   logic signed [NW-1:0] re_in, im_in, n_re, n_im;
   logic [NW-1:0] den_in, bsq;
   logic signed [NW-1:0] mag_re, mag_im;
   cau_pkg::ctl_type ctl_in;
   logic signed [NW-1:0] one;

   always_comb begin
      one    = NW'(1) <<< FRAC_BITS;
      re_in  = '0;
      im_in  = '0;
      ctl_in = '{valid: v1_ff, kind: cau_pkg::KIND_DIRECT, is_equal: eq1_ff, dz: 1'b0};
      bsq    = NW'(PW'(br_ff) * PW'(br_ff)) + NW'(PW'(bi_ff) * PW'(bi_ff));
      n_re   = NW'(rr_ff) + NW'(ii_ff);
      n_im   = NW'(ir_ff) - NW'(ri_ff);
      den_in = bsq;
      unique case (op_ff)
         cau_pkg::OP_ADD:  begin re_in = NW'(ar_ff) + NW'(br_ff); im_in = NW'(ai_ff) + NW'(bi_ff); end
         cau_pkg::OP_SUB:  begin re_in = NW'(ar_ff) - NW'(br_ff); im_in = NW'(ai_ff) - NW'(bi_ff); end
         cau_pkg::OP_MUL:  begin
            re_in = (NW'(rr_ff) - NW'(ii_ff)) >>> FRAC_BITS;
            im_in = (NW'(ri_ff) + NW'(ir_ff)) >>> FRAC_BITS;
         end
         cau_pkg::OP_DIV:  begin
            if (bsq == '0) ctl_in.dz = 1'b1;
            else ctl_in.kind = cau_pkg::KIND_DIV;
         end
         cau_pkg::OP_NEG:  begin re_in = -NW'(ar_ff); im_in = -NW'(ai_ff); end
         cau_pkg::OP_CONJ: begin re_in = NW'(ar_ff); im_in = -NW'(ai_ff); end
         cau_pkg::OP_MOD:  begin
            ctl_in.kind = cau_pkg::KIND_SQRT;
            den_in = NW'(aa_ff) + NW'(bb_ff);
         end
         cau_pkg::OP_INC:  begin re_in = NW'(ar_ff) + one; im_in = NW'(ai_ff); end
         cau_pkg::OP_DEC:  begin re_in = NW'(ar_ff) - one; im_in = NW'(ai_ff); end
         default: ;
      endcase
      mag_re = n_re[NW-1] ? -n_re : n_re;
      mag_im = n_im[NW-1] ? -n_im : n_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl.valid <= 1'b0;
      end else if (enable) begin
         ctl.valid <= ctl_in.valid;
      end
      if (enable) begin
         ctl.kind     <= ctl_in.kind;
         ctl.is_equal <= ctl_in.is_equal;
         ctl.dz       <= ctl_in.dz;
         re_out       <= re_in;
         im_out       <= im_in;
         num_re       <= (ctl_in.kind == cau_pkg::KIND_SQRT) ? '0 : QW'(mag_re) << FRAC_BITS;
         num_im       <= QW'(mag_im) << FRAC_BITS;
         neg_re       <= n_re[NW-1];
         neg_im       <= n_im[NW-1];
         den          <= den_in;
      end
   end

endmodule

@@ sv/cau_cell.sv @@
// ---------------------------------------------------------------------------
// Complex arithmetic unit cell
// One restoring step for both quotients and the square root; hands on.
// ---------------------------------------------------------------------------
module cau_cell #(
   parameter int NW   = 34,
   parameter int QW   = 42,
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  cau_pkg::ctl_type     ctl_i,
   input  logic signed [NW-1:0] re_i,
   input  logic signed [NW-1:0] im_i,
   input  logic [QW-1:0]        qa_i,
   input  logic [QW-1:0]        ra_i,
   input  logic [QW-1:0]        qb_i,
   input  logic [QW-1:0]        rb_i,
   input  logic                 neg_re_i,
   input  logic                 neg_im_i,
   input  logic [NW-1:0]        den_i,
   output cau_pkg::ctl_type     ctl_o,
   output logic signed [NW-1:0] re_o,
   output logic signed [NW-1:0] im_o,
   output logic [QW-1:0]        qa_o,
   output logic [QW-1:0]        ra_o,
   output logic [QW-1:0]        qb_o,
   output logic [QW-1:0]        rb_o,
   output logic                 neg_re_o,
   output logic                 neg_im_o,
   output logic [NW-1:0]        den_o
);

   // Division: qa holds numerator bits shifting in, ra the remainder.
   // Square root (qb/rb unused): ra remainder, qa root, den the radicand.
   localparam int SH = QW - 1 - STEP;
   localparam int RS = (NW / 2) - 1 - STEP;

   logic [QW-1:0] qa_in, ra_in, qb_in, rb_in, t, tb, trial;
   logic [QW:0] tr;

   always_comb begin
      qa_in = qa_i;
      ra_in = ra_i;
      qb_in = qb_i;
      rb_in = rb_i;
      t = '0;
      tb = '0;
      trial = '0;
      tr = '0;
      if (ctl_i.kind == cau_pkg::KIND_DIV) begin
         t = {ra_i[QW-2:0], qa_i[SH]};
         if (t >= QW'(den_i)) begin
            ra_in = t - QW'(den_i);
            qa_in[SH] = 1'b1;
         end else begin
            ra_in = t;
            qa_in[SH] = 1'b0;
         end
         tb = {rb_i[QW-2:0], qb_i[SH]};
         if (tb >= QW'(den_i)) begin
            rb_in = tb - QW'(den_i);
            qb_in[SH] = 1'b1;
         end else begin
            rb_in = tb;
            qb_in[SH] = 1'b0;
         end
      end else if (ctl_i.kind == cau_pkg::KIND_SQRT && RS >= 0) begin
         // Remainder takes the next two radicand bits.
         t = (ra_i << 2) | QW'((den_i >> (2 * (RS >= 0 ? RS : 0))) & NW'(3));
         trial = (qa_i << 2) | QW'(1);
         tr = {1'b0, t} - {1'b0, trial};
         if (!tr[QW]) begin
            ra_in = tr[QW-1:0];
            qa_in = (qa_i << 1) | QW'(1);
         end else begin
            ra_in = t;
            qa_in = qa_i << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_o.valid <= 1'b0;
      end else if (enable) begin
         ctl_o.valid <= ctl_i.valid;
      end
      if (enable) begin
         ctl_o.kind     <= ctl_i.kind;
         ctl_o.is_equal <= ctl_i.is_equal;
         ctl_o.dz       <= ctl_i.dz;
         re_o     <= re_i;
         im_o     <= im_i;
         qa_o     <= qa_in;
         ra_o     <= ra_in;
         qb_o     <= qb_in;
         rb_o     <= rb_in;
         neg_re_o <= neg_re_i;
         neg_im_o <= neg_im_i;
         den_o    <= den_i;
      end
   end

endmodule

@@ sv/complex_arithmetic_unit.sv @@
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Streaming complex ALU on signed fixed point with a chain of divider cells.
// ---------------------------------------------------------------------------
// An item on the req_ channel carries an operation code and two complex
// operands; for each accepted item exactly one result item leaves on the rsp_
// channel, in order. Every operation goes through the same pipeline: two
// front stages (products, then sums), one cell per quotient bit (2*DATA_WIDTH
// + FRAC_BITS + 2 cells, each a restoring step shared by both quotients and
// the square root), and an output register. One item is accepted every
// cycle unless the receiver stalls. The pipeline moves only while the
// output register is empty or being taken, so a stalled receiver holds
// every stage and req_tready falls; nothing is lost. Reset clears all
// valid flags; no clearing pass is needed.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // a_re, a_im, b_re, b_im from the lowest bit up
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]    req_tdata,
   // req_type
   input  logic [cau_pkg::OP_W-1:0]             req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result_re, result_im from the lowest bit up
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // is_equal, divide_by_zero, overflow from the lowest bit up
   output logic [2:0]                           rsp_tuser
);

   localparam int NW = 2 * DATA_WIDTH + 2;
   localparam int QW = 2 * DATA_WIDTH + FRAC_BITS + 2;
   localparam int NC = QW;
   localparam int OW = ((2 * DATA_WIDTH + 7) / 8) * 8;

   logic enable;
   logic out_v_ff;
   assign enable     = !out_v_ff || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = out_v_ff;

   cau_pkg::ctl_type     ctl [NC+1];
   logic signed [NW-1:0] re [NC+1];
   logic signed [NW-1:0] im [NC+1];
   logic [QW-1:0]        qa [NC+1];
   logic [QW-1:0]        ra [NC+1];
   logic [QW-1:0]        qb [NC+1];
   logic [QW-1:0]        rb [NC+1];
   logic                 nre [NC+1];
   logic                 nim [NC+1];
   logic [NW-1:0]        den [NC+1];

   cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .NW(NW), .QW(QW)) u_front (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(req_tvalid),
      .in_op(req_tuser),
      .a_re(req_tdata[DATA_WIDTH-1:0]),
      .a_im(req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .b_re(req_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
      .b_im(req_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH]),
      .ctl(ctl[0]), .re_out(re[0]), .im_out(im[0]),
      .num_re(qa[0]), .num_im(qb[0]),
      .neg_re(nre[0]), .neg_im(nim[0]), .den(den[0])
   );
   assign ra[0] = '0;
   assign rb[0] = '0;

   for (genvar g = 0; g < NC; g++) begin : g_cell
      cau_cell #(.NW(NW), .QW(QW), .STEP(g)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .ctl_i(ctl[g]), .re_i(re[g]), .im_i(im[g]),
         .qa_i(qa[g]), .ra_i(ra[g]), .qb_i(qb[g]), .rb_i(rb[g]),
         .neg_re_i(nre[g]), .neg_im_i(nim[g]), .den_i(den[g]),
         .ctl_o(ctl[g+1]), .re_o(re[g+1]), .im_o(im[g+1]),
         .qa_o(qa[g+1]), .ra_o(ra[g+1]), .qb_o(qb[g+1]), .rb_o(rb[g+1]),
         .neg_re_o(nre[g+1]), .neg_im_o(nim[g+1]), .den_o(den[g+1])
      );
   end

   // Final selection and saturation.
   localparam logic signed [NW-1:0] DMAX = NW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic signed [NW-1:0] DMIN = -DMAX - NW'(1);

   cau_pkg::ctl_type     cf;
   logic signed [NW-1:0] fre, fim;
   logic signed [DATA_WIDTH-1:0] sre, sim;
   logic ov;

   always_comb begin
      cf  = ctl[NC];
      fre = re[NC];
      fim = im[NC];
      unique case (cf.kind)
         cau_pkg::KIND_DIV: begin
            fre = nre[NC] ? -NW'(qa[NC]) : NW'(qa[NC]);
            fim = nim[NC] ? -NW'(qb[NC]) : NW'(qb[NC]);
            if (qa[NC] > QW'(DMAX) + QW'(1)) fre = nre[NC] ? DMIN - NW'(1) : DMAX + NW'(1);
            if (qb[NC] > QW'(DMAX) + QW'(1)) fim = nim[NC] ? DMIN - NW'(1) : DMAX + NW'(1);
         end
         cau_pkg::KIND_SQRT: begin
            fre = NW'(qa[NC]);
            fim = '0;
         end
         default: ;
      endcase
      ov  = 1'b0;
      sre = fre[DATA_WIDTH-1:0];
      sim = fim[DATA_WIDTH-1:0];
      if (fre > DMAX) begin sre = DMAX[DATA_WIDTH-1:0]; ov = 1'b1; end
      if (fre < DMIN) begin sre = DMIN[DATA_WIDTH-1:0]; ov = 1'b1; end
      if (fim > DMAX) begin sim = DMAX[DATA_WIDTH-1:0]; ov = 1'b1; end
      if (fim < DMIN) begin sim = DMIN[DATA_WIDTH-1:0]; ov = 1'b1; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (enable) begin
         out_v_ff <= cf.valid;
      end
      if (enable) begin
         rsp_tdata <= OW'({sim, sre});
         rsp_tuser <= {ov, cf.dz, cf.is_equal};
      end
   end

endmodule
